// ===== src/tpc_pkg.sv =====
package tpc_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int SAMPLE_BITS = 8;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;

    localparam int MASK_W   = 16;
    localparam int PRE_W    = 13;
    localparam int PERIOD_W = 17;
    localparam int SIZE_W   = 13;
    localparam int CFG_W    = 17;
    localparam int CFG_IDX_W = 3;
    localparam int PINS_W   = 16;
    localparam int RIDX_W   = 12;
    localparam int TICK_W   = 16;

    localparam int PERIOD_MAX = 65536;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MASK     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRETRIGGER    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_SIZE  = 3'd4;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_CLEAR = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        MODE_STANDBY = 3'd0,
        MODE_WAIT    = 3'd1,
        MODE_AFTER   = 3'd2,
        MODE_ONCE    = 3'd3,
        MODE_DONE    = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        K_TICK,
        K_START,
        K_STOP,
        K_CLEAR,
        K_READ,
        K_NONE
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic                   hit;
        logic                   in_range;
        logic [SAMPLE_BITS-1:0] sample;
        logic [ADDR_W-1:0]      addr;
    } cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0]   edge_mask;
        logic [MASK_W-1:0]   trigger_level;
        logic [PRE_W-1:0]    pretrigger_count;
        logic [PERIOD_W-1:0] sample_period;
        logic [SIZE_W-1:0]   capture_size;
    } cfg_t;

endpackage

// ===== src/tpc_front.sv =====
module tpc_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   opcode,
    input  logic [tpc_pkg::PINS_W-1:0]   pins,
    input  logic [tpc_pkg::RIDX_W-1:0]   read_index,
    input  tpc_pkg::cfg_t                cfg,
    output logic                         push,
    input  logic                         queue_ready,
    output tpc_pkg::cmd_t                cmd
);
    import tpc_pkg::*;

    logic [PINS_W-1:0] prev_pins_reg;
    logic [PINS_W-1:0] prev_pins_next;
    logic [PINS_W-1:0] rise;
    logic [PINS_W-1:0] fall;
    logic [PINS_W-1:0] hits;
    kind_t             kind;

    assign in_ready = queue_ready;
    assign push     = in_valid && queue_ready;

    // edge test against the previous tick
    assign rise = pins & ~prev_pins_reg;
    assign fall = prev_pins_reg & ~pins;
    assign hits = cfg.edge_mask & ((rise & cfg.trigger_level) | (fall & ~cfg.trigger_level));

    always_comb
    begin
        unique case (opcode)
            OP_TICK:  kind = K_TICK;
            OP_START: kind = K_START;
            OP_STOP:  kind = K_STOP;
            OP_CLEAR: kind = K_CLEAR;
            OP_READ:  kind = K_READ;
            default:  kind = K_NONE;
        endcase
    end

    always_comb
    begin
        cmd.kind     = kind;
        cmd.hit      = |hits;
        cmd.in_range = 32'(read_index) < 32'(STORE_DEPTH);
        cmd.sample   = SAMPLE_BITS'(pins);
        cmd.addr     = ADDR_W'(read_index);
    end

    always_comb
    begin
        prev_pins_next = prev_pins_reg;
        if (push && kind == K_TICK)
        begin
            prev_pins_next = pins;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_pins_reg <= '0;
        end
        else
        begin
            prev_pins_reg <= prev_pins_next;
        end
    end

endmodule

// ===== src/tpc_queue.sv =====
module tpc_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          push_ready,
    input  tpc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          pop_valid,
    output tpc_pkg::cmd_t pop_cmd
);
    import tpc_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/tpc_back.sv =====
module tpc_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_pop,
    input  tpc_pkg::cmd_t                 cmd,
    input  tpc_pkg::cfg_t                 cfg,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    mode,
    output logic                          running,
    output logic                          ready_res,
    output logic [11:0]                   start_index,
    output logic [7:0]                    read_data
);
    import tpc_pkg::*;

    logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
    logic [SAMPLE_BITS-1:0] mem_q_reg;

    mode_t             mode_reg;
    mode_t             mode_next;
    logic              on_reg;
    logic              on_next;
    logic [ADDR_W-1:0] wi_reg;
    logic [ADDR_W-1:0] wi_next;
    logic [TICK_W-1:0] tc_reg;
    logic [TICK_W-1:0] tc_next;
    logic [CNT_W-1:0]  left_reg;
    logic [CNT_W-1:0]  left_next;
    logic [ADDR_W-1:0] oldest_reg;
    logic [ADDR_W-1:0] oldest_next;

    logic              out_valid_reg;
    logic [2:0]        out_mode_reg;
    logic              out_on_reg;
    logic [ADDR_W-1:0] out_oldest_reg;
    logic              rd_sel_reg;

    logic [CNT_W-1:0]    size;
    logic [CNT_W-1:0]    delay;
    logic [PERIOD_W-1:0] period;
    logic [ADDR_W-1:0]   w_eff;
    logic [ADDR_W-1:0]   w_inc;
    logic [CNT_W-1:0]    oldest_calc;
    logic                trig_done;
    logic                mem_we;
    logic                mem_re;

    assign cmd_pop = cmd_valid && (!out_valid_reg || out_ready);

    // effective register values
    always_comb
    begin
        if (cfg.capture_size == '0)
        begin
            size = CNT_W'(1);
        end
        else if (32'(cfg.capture_size) > 32'(STORE_DEPTH))
        begin
            size = CNT_W'(STORE_DEPTH);
        end
        else
        begin
            size = CNT_W'(cfg.capture_size);
        end
        if (32'(cfg.pretrigger_count) > 32'(size))
        begin
            delay = size;
        end
        else
        begin
            delay = CNT_W'(cfg.pretrigger_count);
        end
        if (cfg.sample_period == '0)
        begin
            period = PERIOD_W'(1);
        end
        else if (32'(cfg.sample_period) > PERIOD_MAX)
        begin
            period = PERIOD_W'(PERIOD_MAX);
        end
        else
        begin
            period = cfg.sample_period;
        end
    end

    always_comb
    begin
        w_eff = (CNT_W'(wi_reg) >= size) ? '0 : wi_reg;
        w_inc = (CNT_W'(w_eff) + 1'b1 >= size) ? '0 : w_eff + 1'b1;
        oldest_calc = (CNT_W'(w_eff) >= delay) ? CNT_W'(w_eff) - delay
                                                : CNT_W'(w_eff) + size - delay;
    end

    always_comb
    begin
        mode_next   = mode_reg;
        on_next     = on_reg;
        wi_next     = wi_reg;
        tc_next     = tc_reg;
        left_next   = left_reg;
        oldest_next = oldest_reg;
        trig_done   = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (cmd_pop)
        begin
            unique case (cmd.kind)
                K_TICK:
                begin
                    if (on_reg)
                    begin
                        if (mode_reg == MODE_WAIT && cmd.hit)
                        begin
                            oldest_next = ADDR_W'(oldest_calc);
                            left_next   = size - delay;
                            mode_next   = MODE_AFTER;
                            if (size == delay)
                            begin
                                mode_next = MODE_DONE;
                                on_next   = 1'b0;
                                trig_done = 1'b1;
                            end
                        end
                        if (!trig_done)
                        begin
                            if (PERIOD_W'(tc_reg) + 1'b1 >= period)
                            begin
                                tc_next = '0;
                                mem_we  = 1'b1;
                                wi_next = w_inc;
                                if (mode_next == MODE_AFTER || mode_next == MODE_ONCE)
                                begin
                                    if (left_next != '0)
                                    begin
                                        left_next = left_next - 1'b1;
                                    end
                                    if (left_next == '0)
                                    begin
                                        mode_next = MODE_DONE;
                                        on_next   = 1'b0;
                                    end
                                end
                            end
                            else
                            begin
                                tc_next = tc_reg + 1'b1;
                            end
                        end
                    end
                end
                K_START:
                begin
                    wi_next     = '0;
                    tc_next     = '0;
                    oldest_next = '0;
                    on_next     = 1'b1;
                    if (cfg.edge_mask != '0)
                    begin
                        mode_next = MODE_WAIT;
                        left_next = '0;
                    end
                    else
                    begin
                        mode_next = MODE_ONCE;
                        left_next = size;
                    end
                end
                K_STOP:
                begin
                    on_next = 1'b0;
                end
                K_CLEAR:
                begin
                    mode_next = MODE_STANDBY;
                    on_next   = 1'b0;
                end
                K_READ:
                begin
                    mem_re = cmd.in_range;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_STANDBY;
            on_reg        <= 1'b0;
            wi_reg        <= '0;
            tc_reg        <= '0;
            left_reg      <= '0;
            oldest_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            on_reg     <= on_next;
            wi_reg     <= wi_next;
            tc_reg     <= tc_next;
            left_reg   <= left_next;
            oldest_reg <= oldest_next;
            if (cmd_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            out_mode_reg   <= mode_next;
            out_on_reg     <= on_next;
            out_oldest_reg <= oldest_next;
            rd_sel_reg     <= mem_re;
        end
    end

    // sample store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[w_eff] <= cmd.sample;
        end
        if (mem_re)
        begin
            mem_q_reg <= store[cmd.addr];
        end
    end

    assign out_valid   = out_valid_reg;
    assign mode        = out_mode_reg;
    assign running     = out_on_reg;
    assign ready_res   = out_mode_reg == MODE_DONE;
    assign start_index = (out_mode_reg == MODE_DONE) ? 12'(out_oldest_reg) : '0;
    assign read_data   = rd_sel_reg ? 8'(mem_q_reg) : '0;

endmodule

// ===== src/triggered_pretrigger_capture.sv =====
// channel   direction  beat contents (lowest bits first)
// s_axis    in         tuser: opcode[2:0]; tdata: pins[15:0], read_index[27:16]
// m_axis    out        tdata: mode[2:0], running[3], ready_res[4], start_index[16:5],
//                      read_data[24:17]
// cfg       in         write enable, register index, data; taken every cycle
//
// one beat per cycle while m_axis_tready stays high; a result passes through front
// decode, the queue and the capture engine with its registered store read
// reset clears capture state and loads the register defaults; store contents
// are not cleared
// a two-entry queue parts the input from the engine, so a stalled output
// backs up into s_axis_tready only once the queue is full
module triggered_pretrigger_capture
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [31:0]                      s_axis_tdata,  // pins, read_index
    input  logic [2:0]                       s_axis_tuser,  // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // mode, running, ready_res, start_index, read_data
    output logic [31:0]                      m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [tpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tpc_pkg::CFG_W-1:0]        cfg_data
);
    import tpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic front_push;
    logic queue_ready;
    logic queue_valid;
    logic queue_pop;

    logic [2:0]  mode;
    logic        running;
    logic        ready_res;
    logic [11:0] start_index;
    logic [7:0]  read_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGE_MASK:     cfg_next.edge_mask        = MASK_W'(cfg_data);
                CFG_TRIGGER_LEVEL: cfg_next.trigger_level    = MASK_W'(cfg_data);
                CFG_PRETRIGGER:    cfg_next.pretrigger_count = PRE_W'(cfg_data);
                CFG_SAMPLE_PERIOD: cfg_next.sample_period    = PERIOD_W'(cfg_data);
                CFG_CAPTURE_SIZE:  cfg_next.capture_size     = SIZE_W'(cfg_data);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.edge_mask        <= '0;
            cfg_reg.trigger_level    <= '0;
            cfg_reg.pretrigger_count <= PRE_W'(2048);
            cfg_reg.sample_period    <= PERIOD_W'(720);
            cfg_reg.capture_size     <= SIZE_W'(4096);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tpc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .opcode      (s_axis_tuser),
        .pins        (s_axis_tdata[15:0]),
        .read_index  (s_axis_tdata[27:16]),
        .cfg         (cfg_reg),
        .push        (front_push),
        .queue_ready (queue_ready),
        .cmd         (front_cmd)
    );

    tpc_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (front_push),
        .push_ready (queue_ready),
        .push_cmd   (front_cmd),
        .pop        (queue_pop),
        .pop_valid  (queue_valid),
        .pop_cmd    (queue_cmd)
    );

    tpc_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (queue_valid),
        .cmd_pop     (queue_pop),
        .cmd         (queue_cmd),
        .cfg         (cfg_reg),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .mode        (mode),
        .running     (running),
        .ready_res   (ready_res),
        .start_index (start_index),
        .read_data   (read_data)
    );

    assign m_axis_tdata = {7'd0, read_data, start_index, ready_res, running, mode};

endmodule

// ===== src/tpc_checker.sv =====
module tpc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);
    import tpc_pkg::*;

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // finished flag follows the mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[4] == (m_axis_tdata[2:0] == MODE_DONE))
        else $error("ready_res disagrees with mode");

    // start index only shown for a finished capture
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16:5] != '0 |-> m_axis_tdata[4])
        else $error("start_index shown before capture finished");

    // sampling only in an active capture mode
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |->
            m_axis_tdata[2:0] == MODE_WAIT || m_axis_tdata[2:0] == MODE_AFTER
            || m_axis_tdata[2:0] == MODE_ONCE)
        else $error("running outside an active capture mode");

endmodule

bind triggered_pretrigger_capture tpc_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_triggered_pretrigger_capture.sv =====
module tb_triggered_pretrigger_capture;

    import tpc_pkg::*;

    localparam int OPCODE_MAX = 7;
    localparam int SIZE_REG_MAX = (1 << SIZE_W) - 1;
    localparam int PRE_REG_MAX = (1 << PRE_W) - 1;
    localparam int PERIOD_REG_MAX = (1 << PERIOD_W) - 1;

    class capture_scoreboard;
        logic [SAMPLE_BITS-1:0] store [STORE_DEPTH];
        bit written [STORE_DEPTH];
        int written_q [$];
        mode_t mode;
        int wr_idx;
        int tick_cnt;
        int left;
        int oldest;
        logic [PINS_W-1:0] prev_pins;
        bit sampling;
        logic [MASK_W-1:0] trig_mask;
        logic [MASK_W-1:0] trig_level;
        int pre_count;
        int period;
        int cap_size;
        logic [31:0] expected_q [$];
        int errors;

        function new();
            mode = MODE_STANDBY;
            wr_idx = 0;
            tick_cnt = 0;
            left = 0;
            oldest = 0;
            prev_pins = '0;
            sampling = 0;
            trig_mask = '0;
            trig_level = '0;
            pre_count = 2048;
            period = 720;
            cap_size = 4096;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int value);
            case (idx)
                CFG_EDGE_MASK:     trig_mask = value[MASK_W-1:0];
                CFG_TRIGGER_LEVEL: trig_level = value[MASK_W-1:0];
                CFG_PRETRIGGER:    pre_count = value & PRE_REG_MAX;
                CFG_SAMPLE_PERIOD: period = value & PERIOD_REG_MAX;
                CFG_CAPTURE_SIZE:  cap_size = value & SIZE_REG_MAX;
                default: ;
            endcase
        endfunction

        function int eff_size();
            if (cap_size == 0)
                return 1;
            return (cap_size > STORE_DEPTH) ? STORE_DEPTH : cap_size;
        endfunction

        function int eff_period();
            if (period == 0)
                return 1;
            return (period > PERIOD_MAX) ? PERIOD_MAX : period;
        endfunction

        // random entry among those already holding a sample, -1 if none
        function int pick_written();
            if (written_q.size() == 0)
                return -1;
            return written_q[$urandom_range(0, written_q.size() - 1)];
        endfunction

        function void finish_capture();
            mode = MODE_DONE;
            sampling = 0;
        endfunction

        function void take_sample(logic [PINS_W-1:0] pins);
            if (wr_idx >= eff_size())
                wr_idx = 0;
            store[wr_idx] = pins[SAMPLE_BITS-1:0];
            if (!written[wr_idx])
            begin
                written[wr_idx] = 1;
                written_q.push_back(wr_idx);
            end
            wr_idx = (wr_idx + 1 >= eff_size()) ? 0 : wr_idx + 1;
            if (mode == MODE_AFTER || mode == MODE_ONCE)
            begin
                if (left > 0)
                    left--;
                if (left == 0)
                    finish_capture();
            end
        endfunction

        function void advance_tick(logic [PINS_W-1:0] pins);
            logic [MASK_W-1:0] rise;
            logic [MASK_W-1:0] fall;
            logic [MASK_W-1:0] hit;
            int delay;
            int w;
            rise = pins & ~prev_pins;
            fall = prev_pins & ~pins;
            hit = trig_mask & ((rise & trig_level) | (fall & ~trig_level));
            prev_pins = pins;
            if (!sampling)
                return;
            if (mode == MODE_WAIT && hit != 0)
            begin
                delay = (pre_count > eff_size()) ? eff_size() : pre_count;
                w = (wr_idx >= eff_size()) ? 0 : wr_idx;
                oldest = (w >= delay) ? w - delay : w + eff_size() - delay;
                left = eff_size() - delay;
                mode = MODE_AFTER;
                if (left == 0)
                begin
                    finish_capture();
                    return;
                end
            end
            if (tick_cnt + 1 >= eff_period())
            begin
                tick_cnt = 0;
                take_sample(pins);
            end
            else
                tick_cnt = (tick_cnt + 1) & 'hFFFF;
        endfunction

        function void note_beat(logic [2:0] op, logic [PINS_W-1:0] pins,
                                logic [RIDX_W-1:0] ridx);
            logic [SAMPLE_BITS-1:0] rd;
            logic [11:0] head;
            rd = '0;
            case (op)
                OP_TICK:  advance_tick(pins);
                OP_START:
                begin
                    wr_idx = 0;
                    tick_cnt = 0;
                    oldest = 0;
                    sampling = 1;
                    if (trig_mask != 0)
                    begin
                        mode = MODE_WAIT;
                        left = 0;
                    end
                    else
                    begin
                        mode = MODE_ONCE;
                        left = eff_size();
                    end
                end
                OP_STOP:  sampling = 0;
                OP_CLEAR:
                begin
                    mode = MODE_STANDBY;
                    sampling = 0;
                end
                OP_READ:  rd = store[ridx];
                default: ;
            endcase
            head = (mode == MODE_DONE) ? oldest[11:0] : 12'd0;
            expected_q.push_back({7'd0, rd, head, mode == MODE_DONE, sampling, mode});
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] got);
            logic [31:0] want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            compare_field("mode", want[2:0], got[2:0]);
            compare_field("running", want[3], got[3]);
            compare_field("ready_res", want[4], got[4]);
            compare_field("start_index", want[16:5], got[16:5]);
            compare_field("read_data", want[24:17], got[24:17]);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    capture_scoreboard sb = new();
    bit quiet;
    int beats_sent;
    logic [PINS_W-1:0] last_pins;

    triggered_pretrigger_capture DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // result side back-pressure
    initial
    begin
        int hold;
        hold = 0;
        m_axis_tready = 0;
        forever
        begin
            @(negedge clk);
            if (hold > 0)
            begin
                hold--;
                m_axis_tready = 0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 6);
                m_axis_tready = 0;
            end
            else
                m_axis_tready = 1;
        end
    end

    initial
    begin
        #(12 * 500000);
        $display("triggered_pretrigger_capture: mismatch");
        $finish;
    end

    function automatic logic [PINS_W-1:0] next_pins();
        int r;
        int b;
        r = $urandom_range(0, 9);
        b = $urandom_range(0, PINS_W - 1);
        if (r == 0)
            last_pins = PINS_W'($urandom);
        else if (r <= 3)
            last_pins[b] = ~last_pins[b];
        return last_pins;
    endfunction

    task automatic send_beat(input logic [2:0] op, input logic [PINS_W-1:0] pins,
                             input logic [RIDX_W-1:0] ridx);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser = op;
        s_axis_tdata = {4'd0, ridx, pins};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_beat(op, pins, ridx);
        beats_sent++;
    endtask

    task automatic tick();
        send_beat(OP_TICK, next_pins(), RIDX_W'($urandom));
    endtask

    task automatic tick_with(input logic [PINS_W-1:0] pins);
        last_pins = pins;
        send_beat(OP_TICK, pins, RIDX_W'($urandom));
    endtask

    task automatic send_op(input logic [2:0] op);
        send_beat(op, PINS_W'($urandom), RIDX_W'($urandom));
    endtask

    task automatic read_entry(input int idx);
        send_beat(OP_READ, PINS_W'($urandom), RIDX_W'(idx));
    endtask

    // read back an entry that already holds a sample
    task automatic read_written();
        int idx;
        idx = sb.pick_written();
        if (idx >= 0)
            read_entry(idx);
    endtask

    // hold off until the pipeline is empty
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid = 0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = CFG_W'(value);
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, value);
    endtask

    task automatic configure(input int m, input int lv, input int pre, input int per,
                             input int sz);
        drain();
        write_reg(CFG_EDGE_MASK, m);
        write_reg(CFG_TRIGGER_LEVEL, lv);
        write_reg(CFG_PRETRIGGER, pre);
        write_reg(CFG_SAMPLE_PERIOD, per);
        write_reg(CFG_CAPTURE_SIZE, sz);
    endtask

    task automatic run_random_phase(input int rand_base);
        int r;
        int sz;
        int eff_sz;
        int mask;
        int level;
        int pre;
        int eff_pre;
        int per;
        int eff_per;
        int budget;
        int n;
        bit resized;
        r = $urandom_range(0, 19);
        if (r == 0)
            sz = $urandom_range(STORE_DEPTH, SIZE_REG_MAX);
        else if (r == 1)
            sz = 0;
        else
            sz = $urandom_range(1, 24);
        eff_sz = (sz == 0) ? 1 : (sz > STORE_DEPTH) ? STORE_DEPTH : sz;
        if ($urandom_range(0, 3) == 0 && eff_sz < STORE_DEPTH)
            mask = 0;
        else
            mask = $urandom_range(1, 16'hFFFF);
        level = $urandom_range(0, 16'hFFFF);
        r = $urandom_range(0, 5);
        if (eff_sz == STORE_DEPTH)
            pre = $urandom_range(STORE_DEPTH - 16, STORE_DEPTH);
        else if (r == 0)
            pre = 0;
        else if (r == 1)
            pre = $urandom_range(eff_sz, PRE_REG_MAX);
        else
            pre = $urandom_range(0, eff_sz);
        r = $urandom_range(0, 15);
        if (r == 0)
            per = 0;
        else if (r == 1)
            per = $urandom_range(PERIOD_MAX, PERIOD_REG_MAX);
        else if (r <= 5)
            per = $urandom_range(2, 6);
        else
            per = 1;
        eff_per = (per == 0) ? 1 : (per > PERIOD_MAX) ? PERIOD_MAX : per;
        eff_pre = (pre > eff_sz) ? eff_sz : pre;
        if (eff_per > 6)
            budget = 40;
        else
            budget = ((mask != 0) ? eff_sz - eff_pre : eff_sz) * eff_per + 40;

        configure(mask, level, pre, per, sz);
        quiet = (beats_sent - rand_base > 850) || ($urandom_range(0, 4) == 0);
        resized = 0;
        send_op(OP_START);
        for (n = 0; n < budget && sb.mode != MODE_DONE; n++)
        begin
            r = $urandom_range(0, 39);
            case (r)
                0: read_written();
                1: send_op(3'($urandom_range(OP_READ + 1, OPCODE_MAX)));
                2:
                begin
                    send_op(OP_STOP);
                    if ($urandom_range(0, 1))
                        send_op(OP_START);
                end
                3: send_op(OP_START);
                4:
                begin
                    // shrink or keep the capture size under a running capture
                    if (!resized && sb.sampling)
                    begin
                        drain();
                        write_reg(CFG_CAPTURE_SIZE, $urandom_range(1, eff_sz));
                        resized = 1;
                    end
                    else
                        tick();
                end
                default: tick();
            endcase
        end
        repeat ($urandom_range(0, 3)) read_written();
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            send_op(OP_START);
            send_op(OP_CLEAR);
        end
        else if (r == 1)
            send_op(OP_CLEAR);
        else if (r == 2)
            send_op(OP_STOP);
    endtask

    initial
    begin
        int rand_base;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        cfg_we = 0;
        cfg_index = '0;
        cfg_data = '0;
        last_pins = '0;
        beats_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // register defaults: single run, no sample yet within a short burst
        send_op(OP_START);
        repeat (24) tick();
        send_op(OP_STOP);
        send_op(OP_CLEAR);

        // pretrigger clipped to the size finishes at once on the trigger; then unused opcodes
        configure(16'hFFFF, 16'hFFFF, PRE_REG_MAX, PERIOD_REG_MAX, 0);
        send_op(OP_START);
        tick_with(16'h0000);
        tick_with(16'hFFFF);
        send_op(OP_START);
        send_op(3'(OP_READ + 1));
        send_op(3'(OP_READ + 2));
        send_op(3'(OPCODE_MAX));
        send_op(OP_CLEAR);

        // falling edge on the top pin, no pretrigger history
        configure(16'h8000, 0, 0, 2, 4);
        send_op(OP_START);
        tick_with(16'hFFFF);
        tick_with(16'hFFFF);
        tick_with(16'h7FFF);
        while (sb.mode != MODE_DONE)
            tick();
        read_entry(0);
        send_op(OP_STOP);

        rand_base = beats_sent;
        while (beats_sent - rand_base < 1000)
            run_random_phase(rand_base);

        drain();
        quiet = 1;
        for (int i = 0; i < 5000 && sb.expected_q.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.expected_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.expected_q.size());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("triggered_pretrigger_capture: match");
        else
            $display("triggered_pretrigger_capture: mismatch");
        $finish;
    end

endmodule
